@@ src/bearing_atan2_table_defines.svh @@
// Assertion macros for the bearing_atan2_table block.
// Included by the top level; no other dependencies.
`ifndef BEARING_ATAN2_TABLE_DEFINES_SVH
`define BEARING_ATAN2_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define BAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bearing_atan2_table: check failed");
`define BAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bearing_atan2_table: check failed");
`else
`define BAT_ASSERT_IMP(lbl, ante, cons)
`define BAT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/bat_pkg.sv @@
// Shared types, constants and the arctangent ROM builder for bearing_atan2_table.
// No dependencies.
package bat_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int LOG_STEPS       = 10;
  localparam int TABLE_STEPS     = 1 << LOG_STEPS;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int IDX_W           = LOG_STEPS + 1;
  localparam int ROM_W           = ANGLE_FRAC_BITS + 6;   // 45 degrees needs 6 integer bits
  localparam int BEARING_W       = 25;
  localparam int BASE_W          = 9;
  localparam int MAG_W           = COORD_WIDTH;
  localparam int REM_W           = COORD_WIDTH + 1;
  localparam int DIV_STAGES      = LOG_STEPS + 1;
  localparam int QBITS           = 48;
  localparam int Q_DEPTH         = 4;
  localparam int QPTR_W          = 2;
  localparam int QCNT_W          = 3;

  localparam logic [BASE_W-1:0] BASE_0   = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_90  = BASE_W'(90);
  localparam logic [BASE_W-1:0] BASE_180 = BASE_W'(180);
  localparam logic [BASE_W-1:0] BASE_270 = BASE_W'(270);
  localparam logic [BASE_W-1:0] BASE_360 = BASE_W'(360);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [BEARING_W-1:0] bearing;
    logic                 zero_vector;
  } out_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [BASE_W-1:0] base;
    logic              add;
    logic              zero;
  } class_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [MAG_W-1:0]  den;
    logic [IDX_W-1:0]  quo;
    logic [BASE_W-1:0] base;
    logic              add;
    logic              zero;
  } div_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              add;
    logic              zero;
  } fold_t;

  typedef logic [ROM_W-1:0] rom_t [0:TABLE_STEPS];

  // shift-subtract division for the ROM builder; returns remainder when want_rem is set
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b,
                                             bit want_rem);
    longint unsigned q;
    longint unsigned r;
    int k;
    q = 0;
    r = 0;
    for (k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return want_rem ? r : q;
  endfunction

  // atan(p/q) in radians, Q48 series
  function automatic longint unsigned atan_q48(longint unsigned p, longint unsigned q);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned t;
    int n;
    term = udiv64((64'd1 << QBITS) * p, q, 1'b0);
    sum  = 0;
    for (n = 0; n < 64; n++) begin
      if (term != 0) begin
        t = udiv64(term, longint'(2 * n + 1), 1'b0);
        if (n[0] == 1'b0) sum = sum + t;
        else sum = sum - t;
        term = udiv64(term * p, q, 1'b0);
        term = udiv64(term * p, q, 1'b0);
      end
    end
    return sum;
  endfunction

  // radians Q48 to degrees with ANGLE_FRAC_BITS fraction, round half up
  function automatic longint unsigned to_degrees(longint unsigned rad, longint unsigned qpi);
    longint unsigned num;
    longint unsigned ip;
    longint unsigned r;
    longint unsigned frac;
    int b;
    num  = rad * 45;
    ip   = udiv64(num, qpi, 1'b0);
    r    = udiv64(num, qpi, 1'b1);
    frac = 0;
    for (b = 0; b < ANGLE_FRAC_BITS + 1; b++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= qpi) begin
        r    = r - qpi;
        frac = frac | 64'd1;
      end
    end
    return (((ip << (ANGLE_FRAC_BITS + 1)) | frac) + 64'd1) >> 1;
  endfunction

  function automatic rom_t build_rom();
    rom_t            tbl;
    longint unsigned qpi;
    longint unsigned rad;
    longint unsigned ts;
    int i;
    ts  = longint'(TABLE_STEPS);
    qpi = 4 * atan_q48(64'd1, 64'd5) - atan_q48(64'd1, 64'd239);
    for (i = 0; i <= TABLE_STEPS; i++) begin
      if (2 * i <= TABLE_STEPS) rad = atan_q48(longint'(i), ts);
      else rad = qpi - atan_q48(ts - longint'(i), ts + longint'(i));
      tbl[i] = ROM_W'(to_degrees(rad, qpi));
    end
    return tbl;
  endfunction

endpackage

@@ src/bat_front.sv @@
// Front end: accepts input vectors, sorts them into octants and queues them.
// Depends on bat_pkg.
module bat_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  bat_pkg::in_item_t in_data,
  input  logic              deq,
  output logic              q_valid,
  output bat_pkg::class_t   q_head
);

  bat_pkg::class_t                   cls;
  bat_pkg::class_t                   mem_r [bat_pkg::Q_DEPTH];
  logic [bat_pkg::QPTR_W-1:0]        wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [bat_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [bat_pkg::REM_W-1:0]  xs, ys;
  logic [bat_pkg::MAG_W-1:0]         ax, ay;
  logic                              wr, rd;

  always_comb begin
    xs = {in_data.x_coord[bat_pkg::COORD_WIDTH-1], in_data.x_coord};
    ys = {in_data.y_coord[bat_pkg::COORD_WIDTH-1], in_data.y_coord};
    ax = xs[bat_pkg::REM_W-1] ? bat_pkg::MAG_W'(-xs) : bat_pkg::MAG_W'(xs);
    ay = ys[bat_pkg::REM_W-1] ? bat_pkg::MAG_W'(-ys) : bat_pkg::MAG_W'(ys);
    cls.zero = (ax == '0) && (ay == '0);
    // ties go the way of the octant sort: equal magnitudes take the adding branch
    unique case ({xs[bat_pkg::REM_W-1], ys[bat_pkg::REM_W-1]})
      2'b00: begin
        if (ay >= ax) begin
          cls.num = ax; cls.den = ay; cls.base = bat_pkg::BASE_0; cls.add = 1'b1;
        end else begin
          cls.num = ay; cls.den = ax; cls.base = bat_pkg::BASE_90; cls.add = 1'b0;
        end
      end
      2'b01: begin
        if (ax >= ay) begin
          cls.num = ay; cls.den = ax; cls.base = bat_pkg::BASE_90; cls.add = 1'b1;
        end else begin
          cls.num = ax; cls.den = ay; cls.base = bat_pkg::BASE_180; cls.add = 1'b0;
        end
      end
      2'b11: begin
        if (ay >= ax) begin
          cls.num = ax; cls.den = ay; cls.base = bat_pkg::BASE_180; cls.add = 1'b1;
        end else begin
          cls.num = ay; cls.den = ax; cls.base = bat_pkg::BASE_270; cls.add = 1'b0;
        end
      end
      default: begin
        if (ax >= ay) begin
          cls.num = ay; cls.den = ax; cls.base = bat_pkg::BASE_270; cls.add = 1'b1;
        end else begin
          cls.num = ax; cls.den = ay; cls.base = bat_pkg::BASE_360; cls.add = 1'b0;
        end
      end
    endcase
  end

  assign full    = (cnt_r == bat_pkg::QCNT_W'(bat_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rptr_r];
  assign wr      = push && !full;
  assign rd      = deq && q_valid;

  always_comb begin
    wptr_nxt = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + bat_pkg::QCNT_W'(wr) - bat_pkg::QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wptr_r] <= cls;
  end

endmodule

@@ src/bat_back.sv @@
// Back end: pipelined ratio divider, arctangent ROM and octant fold.
// Depends on bat_pkg.
module bat_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 src_valid,
  input  bat_pkg::class_t      src_item,
  output logic                 deq,
  output logic                 res_valid,
  output bat_pkg::out_item_t   res_item
);

  localparam bat_pkg::rom_t ATAN_ROM = bat_pkg::build_rom();

  bat_pkg::div_t                         st_r [bat_pkg::DIV_STAGES];
  bat_pkg::div_t                         st_nxt [bat_pkg::DIV_STAGES];
  bat_pkg::div_t                         init;
  logic [bat_pkg::DIV_STAGES-1:0]        v_r;
  logic                                  rom_v_r;
  logic [bat_pkg::ROM_W-1:0]             rom_d_r;
  bat_pkg::fold_t                        fold_r;
  bat_pkg::div_t                         last;
  logic [bat_pkg::IDX_W-1:0]             idx;
  logic [bat_pkg::BEARING_W-1:0]         base_fx;

  // one quotient bit per stage; the first stage compares without shifting
  function automatic bat_pkg::div_t div_step(bat_pkg::div_t s, logic first);
    bat_pkg::div_t          o;
    logic [bat_pkg::REM_W-1:0] r;
    o = s;
    r = first ? s.rem : {s.rem[bat_pkg::REM_W-2:0], 1'b0};
    if (r >= {1'b0, s.den}) begin
      o.rem = r - {1'b0, s.den};
      o.quo = {s.quo[bat_pkg::IDX_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {s.quo[bat_pkg::IDX_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign deq = adv && src_valid;

  always_comb begin
    init.rem  = {1'b0, src_item.num};
    init.den  = src_item.den;
    init.quo  = '0;
    init.base = src_item.base;
    init.add  = src_item.add;
    init.zero = src_item.zero;
    st_nxt[0] = div_step(init, 1'b1);
    for (int k = 1; k < bat_pkg::DIV_STAGES; k++) begin
      st_nxt[k] = div_step(st_r[k-1], 1'b0);
    end
  end

  assign last = st_r[bat_pkg::DIV_STAGES-1];
  // only a zero divisor can push the quotient past the table end
  assign idx  = (last.quo > bat_pkg::IDX_W'(bat_pkg::TABLE_STEPS))
              ? bat_pkg::IDX_W'(bat_pkg::TABLE_STEPS) : last.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      rom_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[bat_pkg::DIV_STAGES-2:0], src_valid};
      rom_v_r <= v_r[bat_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < bat_pkg::DIV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      rom_d_r     <= ATAN_ROM[idx];
      fold_r.base <= last.base;
      fold_r.add  <= last.add;
      fold_r.zero <= last.zero;
    end
  end

  always_comb begin
    base_fx = {fold_r.base, bat_pkg::ANGLE_FRAC_BITS'(0)};
    res_valid = rom_v_r;
    res_item.zero_vector = fold_r.zero;
    if (fold_r.zero) res_item.bearing = '0;
    else if (fold_r.add) res_item.bearing = base_fx + bat_pkg::BEARING_W'(rom_d_r);
    else res_item.bearing = base_fx - bat_pkg::BEARING_W'(rom_d_r);
  end

endmodule

@@ src/bat_outq.sv @@
// Result queue between the back end and the output port.
// Depends on bat_pkg.
module bat_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  bat_pkg::out_item_t wr_item,
  output logic               q_full,
  output logic               empty,
  input  logic               pop,
  output bat_pkg::out_item_t out_data
);

  bat_pkg::out_item_t          mem_r [bat_pkg::Q_DEPTH];
  logic [bat_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [bat_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        wr, rd;

  assign q_full   = (cnt_r == bat_pkg::QCNT_W'(bat_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_data = mem_r[rptr_r];
  assign wr       = wr_en && !q_full;
  assign rd       = pop && !empty;

  always_comb begin
    wptr_nxt = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + bat_pkg::QCNT_W'(wr) - bat_pkg::QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wptr_r] <= wr_item;
  end

endmodule

@@ src/bearing_atan2_table.sv @@
// bearing_atan2_table: bearing of a signed (x, y) vector, clockwise from +y.
// An accepted push passes the front queue, the divider and the ROM register to the result queue.
// Throughput: one vector per cycle unless stalled; 11 divider stages, one quotient bit each,
// followed by a registered ROM read. The back end stalls as a whole when the result queue fills.
// Reset (rst_n, synchronous): both queues and all pipeline valid bits clear; the ROM is constant.
// Depends on bat_pkg, bat_front, bat_back, bat_outq and bearing_atan2_table_defines.svh.
module bearing_atan2_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bat_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output bat_pkg::out_item_t out_data
);

  `include "bearing_atan2_table_defines.svh"

  bat_pkg::class_t    q_head;
  bat_pkg::out_item_t res_item;
  logic               q_valid, deq, res_valid, oq_full, adv;

  assign adv = !oq_full;

  bat_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .deq     (deq),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  bat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .src_valid (q_valid),
    .src_item  (q_head),
    .deq       (deq),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  bat_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (adv && res_valid),
    .wr_item  (res_item),
    .q_full   (oq_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  `BAT_ASSERT_IMP(a_zero_bearing, !empty && out_data.zero_vector, out_data.bearing == '0)
  `BAT_ASSERT_IMP(a_bearing_range, !empty,
                  out_data.bearing <= bat_pkg::BEARING_W'(360 << bat_pkg::ANGLE_FRAC_BITS))
  `BAT_ASSERT_NEXT(a_stall_holds, res_valid && !adv, res_valid)

endmodule
